// ===== src/two_table_cuckoo_hash_top_macros.svh =====
// Assertion helpers for the cuckoo hash controller
`ifndef TWO_TABLE_CUCKOO_HASH_TOP_MACROS_SVH
`define TWO_TABLE_CUCKOO_HASH_TOP_MACROS_SVH

// Check that expr holds in the same cycle as trig
`define CTH_ASSERT_SAME(label, clk, rst_n, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error("cuckoo hash check failed");

// Check that expr holds in the cycle after trig
`define CTH_ASSERT_NEXT(label, clk, rst_n, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("cuckoo hash check failed");

`endif

// ===== src/cth_pkg.sv =====
package cth_pkg;

    localparam int SLOTS_DEF     = 1024;
    localparam int LOG_DEPTH_DEF = 64;
    localparam int KEY_W         = 31;
    localparam int CFG_W         = 11;
    localparam int CFG_RESET     = 1024;
    localparam int IN_W          = 40;
    localparam int OUT_W         = 48;

    // Request kinds
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    // Result codes
    localparam logic [2:0] ST_DIRECT   = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_PRESENT  = 3'd2;
    localparam logic [2:0] ST_PLACED   = 3'd3;
    localparam logic [2:0] ST_CYCLE    = 3'd4;
    localparam logic [2:0] ST_LOGFULL  = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HS, S_HD1, S_HD2, S_RD0, S_CK0, S_CK1,
        S_KS, S_KD1, S_KD2, S_LRD, S_LCK, S_KRD, S_KPL, S_FIN
    } state_t;

    typedef struct packed {
        logic       clr_we;
        logic       load_req;
        logic       div_start;
        logic       div_quot;
        logic       div_carry;
        logic       save_kh;
        logic       save_kg;
        logic       save_ch;
        logic       save_cg;
        logic       rd_t1g;
        logic       rd_kick;
        logic       cap0;
        logic       wr_del;
        logic       wr_key_t0h;
        logic       kick_init;
        logic       wr_kick;
        logic       advance;
        logic       log_i_clr;
        logic       log_next;
        logic       log_upd;
        logic       log_app;
        logic       res_we;
        logic [2:0] res_status;
        logic       res_found;
        logic       res_drop;
        logic       drop_prev;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       div_done;
        logic [1:0] act;
        logic       hit0;
        logic       hit1;
        logic       t0_valid;
        logic       rvalid;
        logic       log_match;
        logic       log_more;
        logic       log_full;
        logic       cnt3;
        logic       out_free;
    } sts_t;

endpackage

// ===== src/cth_ram.sv =====
module cth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/cth_div.sv =====
module cth_div #(
    parameter int NW = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cth_pkg::KEY_W-1:0] dividend,
    input  logic [NW-1:0]             divisor,
    output logic [cth_pkg::KEY_W-1:0] quo,
    output logic [NW-1:0]             rem,
    output logic                      done
);
    import cth_pkg::*;

    localparam int CW = $clog2(KEY_W);

    logic [KEY_W-1:0] quo_reg;
    logic [NW-1:0]    rem_reg;
    logic [NW-1:0]    div_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [NW:0]      trial;
    logic             ge;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[KEY_W-1]};
        ge    = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(KEY_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring divide, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[KEY_W-2:0], ge};
            rem_reg <= ge ? NW'(trial - {1'b0, div_reg}) : NW'(trial);
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ===== src/cth_dp.sv =====
module cth_dp #(
    parameter int SLOTS     = cth_pkg::SLOTS_DEF,
    parameter int LOG_DEPTH = cth_pkg::LOG_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [cth_pkg::CFG_W-1:0] cfg_wdata,
    input  logic [cth_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [cth_pkg::OUT_W-1:0] m_tdata,
    input  cth_pkg::cmd_t             cmd,
    output cth_pkg::sts_t             sts
);
    import cth_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int NW = $clog2(SLOTS + 1);
    localparam int AW = IW + 1;
    localparam int LW = $clog2(LOG_DEPTH);
    localparam int FW = $clog2(LOG_DEPTH + 1);
    localparam int EW = KEY_W + 1;
    localparam int LEW = KEY_W + 3;

    logic [CFG_W-1:0] cfg_reg;
    logic [NW-1:0]    n_eff;
    logic [1:0]       act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] carry_reg;
    logic             tbl_reg;
    logic [IW-1:0]    kh_reg, kg_reg, ch_reg, cg_reg;
    logic             hit0_reg;
    logic [EW-1:0]    t0_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic [LW-1:0]    li_reg;
    logic [FW-1:0]    fill_reg;
    logic             cnt3_reg;
    logic [2:0]       rs_status_reg;
    logic [9:0]       rs_slot_reg;
    logic             rs_tbl_reg;
    logic             rs_dv_reg;
    logic [KEY_W-1:0] rs_dk_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic [KEY_W-1:0] div_dividend, div_quo;
    logic [NW-1:0]    div_rem;
    logic             div_done;
    logic             t_we;
    logic [AW-1:0]    t_waddr, t_raddr;
    logic [EW-1:0]    t_wdata, t_rdata;
    logic             l_we;
    logic [LW-1:0]    l_waddr;
    logic [LEW-1:0]   l_wdata, l_rdata;
    logic             hit1;
    logic [IW-1:0]    fslot, kick_idx;
    logic             ftbl;
    logic [1:0]       new_cnt;

    // Clamp the register into a legal modulus
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(cfg_reg) > 32'(SLOTS))
        begin
            n_eff = NW'(SLOTS);
        end
        else
        begin
            n_eff = NW'(cfg_reg);
        end
    end

    always_comb
    begin
        if (cmd.div_quot)
        begin
            div_dividend = div_quo;
        end
        else if (cmd.div_carry)
        begin
            div_dividend = carry_reg;
        end
        else
        begin
            div_dividend = key_reg;
        end
    end

    cth_div #(.NW(NW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (n_eff),
        .quo      (div_quo),
        .rem      (div_rem),
        .done     (div_done)
    );

    // Lookup results
    assign hit1     = t_rdata[KEY_W] && (t_rdata[KEY_W-1:0] == key_reg);
    assign fslot    = hit0_reg ? kh_reg : (hit1 ? kg_reg : '0);
    assign ftbl     = !hit0_reg && hit1;
    assign kick_idx = tbl_reg ? cg_reg : ch_reg;

    // Table port selection
    always_comb
    begin
        t_we    = 1'b0;
        t_waddr = {1'b0, kh_reg};
        t_wdata = {1'b1, key_reg};
        if (cmd.clr_we)
        begin
            t_we    = 1'b1;
            t_waddr = clr_cnt_reg;
            t_wdata = '0;
        end
        else if (cmd.wr_del)
        begin
            t_we    = 1'b1;
            t_waddr = {ftbl, fslot};
            t_wdata = '0;
        end
        else if (cmd.wr_key_t0h || cmd.kick_init)
        begin
            t_we = 1'b1;
        end
        else if (cmd.wr_kick)
        begin
            t_we    = 1'b1;
            t_waddr = {tbl_reg, kick_idx};
            t_wdata = {1'b1, carry_reg};
        end
    end

    always_comb
    begin
        if (cmd.rd_kick)
        begin
            t_raddr = {tbl_reg, kick_idx};
        end
        else if (cmd.rd_t1g)
        begin
            t_raddr = {1'b1, kg_reg};
        end
        else
        begin
            t_raddr = {1'b0, kh_reg};
        end
    end

    cth_ram #(.WIDTH(EW), .DEPTH(2 << IW)) u_tables (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // Visit log port selection; entry is {count, table, key}
    assign new_cnt = (l_rdata[LEW-1:LEW-2] == 2'd3) ? 2'd3 : l_rdata[LEW-1:LEW-2] + 2'd1;

    always_comb
    begin
        l_we    = 1'b0;
        l_waddr = LW'(fill_reg);
        l_wdata = {2'd1, tbl_reg, carry_reg};
        if (cmd.kick_init)
        begin
            l_we    = 1'b1;
            l_waddr = '0;
            l_wdata = {2'd1, 1'b0, key_reg};
        end
        else if (cmd.log_upd)
        begin
            l_we    = 1'b1;
            l_waddr = li_reg;
            l_wdata = {new_cnt, tbl_reg, carry_reg};
        end
        else if (cmd.log_app)
        begin
            l_we = 1'b1;
        end
    end

    cth_ram #(.WIDTH(LEW), .DEPTH(LOG_DEPTH)) u_log (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (li_reg),
        .rdata (l_rdata)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_W'(CFG_RESET);
            clr_cnt_reg   <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (cmd.clr_we)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.kick_init)
            begin
                fill_reg <= FW'(1);
            end
            else if (cmd.log_app)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            act_reg <= s_tdata[1:0];
            key_reg <= s_tdata[KEY_W+1:2];
        end
        if (cmd.save_kh) kh_reg <= IW'(div_rem);
        if (cmd.save_kg) kg_reg <= IW'(div_rem);
        if (cmd.save_ch) ch_reg <= IW'(div_rem);
        if (cmd.save_cg) cg_reg <= IW'(div_rem);
        if (cmd.cap0)
        begin
            hit0_reg <= t_rdata[KEY_W] && (t_rdata[KEY_W-1:0] == key_reg);
            t0_reg   <= t_rdata;
        end
        if (cmd.kick_init)
        begin
            carry_reg <= t0_reg[KEY_W-1:0];
            tbl_reg   <= 1'b1;
        end
        else if (cmd.advance)
        begin
            carry_reg <= t_rdata[KEY_W-1:0];
            tbl_reg   <= !tbl_reg;
        end
        if (cmd.log_i_clr)
        begin
            li_reg <= '0;
        end
        else if (cmd.log_next)
        begin
            li_reg <= li_reg + 1'b1;
        end
        if (cmd.log_upd)
        begin
            cnt3_reg <= (new_cnt == 2'd3);
        end
        else if (cmd.log_app)
        begin
            cnt3_reg <= 1'b0;
        end
        if (cmd.res_we)
        begin
            rs_status_reg <= cmd.res_status;
            rs_slot_reg   <= cmd.res_found ? 10'(fslot) : 10'(kh_reg);
            rs_tbl_reg    <= cmd.res_found ? ftbl : 1'b0;
            rs_dv_reg     <= cmd.res_drop;
            rs_dk_reg     <= !cmd.res_drop ? '0 :
                             (cmd.drop_prev ? t_rdata[KEY_W-1:0] : carry_reg);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {2'b00, rs_dk_reg, rs_dv_reg, rs_tbl_reg,
                             rs_slot_reg, rs_status_reg};
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.clr_done  = &clr_cnt_reg;
        sts.div_done  = div_done;
        sts.act       = act_reg;
        sts.hit0      = hit0_reg;
        sts.hit1      = hit1;
        sts.t0_valid  = t0_reg[KEY_W];
        sts.rvalid    = t_rdata[KEY_W];
        sts.log_match = (l_rdata[KEY_W-1:0] == carry_reg) && (l_rdata[KEY_W] == tbl_reg);
        sts.log_more  = (FW'(li_reg) + FW'(1)) < fill_reg;
        sts.log_full  = (32'(fill_reg) >= 32'(LOG_DEPTH));
        sts.cnt3      = cnt3_reg;
        sts.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== src/cth_ctrl.sv =====
`include "two_table_cuckoo_hash_top_macros.svh"

module cth_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  cth_pkg::sts_t sts,
    output cth_pkg::cmd_t cmd
);
    import cth_pkg::*;

    state_t state_reg, state_next;
    logic   found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign found = sts.hit0 || sts.hit1;

    // Sequence table clearing, lookups, evictions and result delivery
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_HS;
                end
            end
            S_HS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_HD1;
            end
            S_HD1:
            begin
                if (sts.div_done)
                begin
                    cmd.save_kh   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_quot  = 1'b1;
                    state_next    = S_HD2;
                end
            end
            S_HD2:
            begin
                if (sts.div_done)
                begin
                    cmd.save_kg = 1'b1;
                    state_next  = S_RD0;
                end
            end
            S_RD0:
            begin
                state_next = S_CK0;
            end
            S_CK0:
            begin
                cmd.cap0   = 1'b1;
                cmd.rd_t1g = 1'b1;
                state_next = S_CK1;
            end
            S_CK1:
            begin
                if (sts.act != ACT_INSERT)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_found  = 1'b1;
                    cmd.res_status = found ? ST_DIRECT : ST_NOTFOUND;
                    cmd.wr_del     = found && (sts.act == ACT_DELETE);
                    state_next     = S_FIN;
                end
                else if (found)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_found  = 1'b1;
                    cmd.res_status = ST_PRESENT;
                    state_next     = S_FIN;
                end
                else if (!sts.t0_valid)
                begin
                    cmd.wr_key_t0h = 1'b1;
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_DIRECT;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.kick_init = 1'b1;
                    state_next    = S_KS;
                end
            end
            S_KS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_carry = 1'b1;
                state_next    = S_KD1;
            end
            S_KD1:
            begin
                if (sts.div_done)
                begin
                    cmd.save_ch   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_quot  = 1'b1;
                    state_next    = S_KD2;
                end
            end
            S_KD2:
            begin
                if (sts.div_done)
                begin
                    cmd.save_cg   = 1'b1;
                    cmd.log_i_clr = 1'b1;
                    state_next    = S_LRD;
                end
            end
            S_LRD:
            begin
                state_next = S_LCK;
            end
            S_LCK:
            begin
                if (sts.log_match)
                begin
                    cmd.log_upd = 1'b1;
                    state_next  = S_KRD;
                end
                else if (sts.log_more)
                begin
                    cmd.log_next = 1'b1;
                    state_next   = S_LRD;
                end
                else if (sts.log_full)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_LOGFULL;
                    cmd.res_drop   = 1'b1;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.log_app = 1'b1;
                    state_next  = S_KRD;
                end
            end
            S_KRD:
            begin
                cmd.rd_kick = 1'b1;
                state_next  = S_KPL;
            end
            S_KPL:
            begin
                cmd.wr_kick = 1'b1;
                if (!sts.rvalid)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_PLACED;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    if (sts.cnt3)
                    begin
                        cmd.res_we     = 1'b1;
                        cmd.res_status = ST_CYCLE;
                        cmd.res_drop   = 1'b1;
                        cmd.drop_prev  = 1'b1;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        state_next = S_KS;
                    end
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `CTH_ASSERT_NEXT(a_accept_starts_hash, clk, rst_n, s_tvalid && s_tready, state_reg == S_HS)
    `CTH_ASSERT_NEXT(a_result_then_fin, clk, rst_n, cmd.res_we, state_reg == S_FIN)
    `CTH_ASSERT_SAME(a_no_accept_clearing, clk, rst_n, state_reg == S_CLEAR, !s_tready)
    `CTH_ASSERT_NEXT(a_load_then_idle, clk, rst_n, cmd.out_load, state_reg == S_IDLE)

endmodule

// ===== src/two_table_cuckoo_hash_top.sv =====
// Channel   Direction  Width  Contents
// s_*       in         40     request beat: action, key
// m_*       out        48     result beat: status, slot, which_table, dropped fields
// cfg_*     in         11     slots_in_use write
//
// Each request is paced by the bit-serial divider, two divisions per hash. An insert adds
// a hash and a serial log search per eviction. After reset a clearing pass empties the tables;
// no beat is taken meanwhile. A finished result is held until m_tready; the next beat may be
// accepted while it waits.
module two_table_cuckoo_hash_top #(
    parameter int SLOTS     = cth_pkg::SLOTS_DEF,
    parameter int LOG_DEPTH = cth_pkg::LOG_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [cth_pkg::IN_W-1:0]  s_tdata,   // action[1:0], key[32:2]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status, slot, which_table, dropped_valid, dropped_key
    output logic [cth_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_wen,
    input  logic [cth_pkg::CFG_W-1:0] cfg_wdata
);
    import cth_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cth_dp #(.SLOTS(SLOTS), .LOG_DEPTH(LOG_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== verif/two_table_cuckoo_hash_top_tb.sv =====
`timescale 1ns / 1ps

module two_table_cuckoo_hash_top_tb;
    import cth_pkg::*;

    localparam int NSLOT = 1024;
    localparam int NLOG = 64;
    localparam longint CYCLE_LIMIT = 250000000;
    localparam int PHASE_ITEMS = 125;
    localparam logic [1:0] ACT_SEARCH = 2'd0;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // Packed from the top bit down, so status lands in the lowest bits
    typedef struct packed {
        logic [KEY_W-1:0] dropped_key;
        logic             dropped_valid;
        logic             which_table;
        logic [9:0]       slot;
        logic [2:0]       status;
    } hash_result_t;

    typedef struct {
        logic [1:0]       act;
        logic [KEY_W-1:0] key;
        bit               known;
        hash_result_t     res;
    } request_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_wen = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // Shadow copy of both tables, the visit log and the modulus register
    bit               shadow_valid [2][NSLOT];
    logic [KEY_W-1:0] shadow_key [2][NSLOT];
    logic [KEY_W-1:0] visit_key [NLOG];
    bit               visit_tbl [NLOG];
    int unsigned      visit_cnt [NLOG];
    int unsigned      visit_fill;
    int unsigned      slots_reg;

    hash_result_t      pending_results[$];
    logic [KEY_W-1:0]  key_pool[$];
    int                errors = 0;
    longint            cycle_count = 0;
    bit                tx_idle = 1'b0;
    bit                rx_idle = 1'b0;
    int unsigned       idle_pct = 77;
    bit                hold_req = 1'b0;
    int                hold_left = 0;

    two_table_cuckoo_hash_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned modulus_now();
        int unsigned n;
        n = slots_reg;
        if (n == 0) n = 1;
        if (n > NSLOT) n = NSLOT;
        return n;
    endfunction

    // Record a visit; return the count after it, 0 when the log has no room
    function automatic int unsigned log_visit(logic [KEY_W-1:0] key, bit tbl);
        for (int i = 0; i < visit_fill; i++)
        begin
            if (visit_key[i] == key && visit_tbl[i] == tbl)
            begin
                if (visit_cnt[i] < 3) visit_cnt[i]++;
                return visit_cnt[i];
            end
        end
        if (visit_fill >= NLOG) return 0;
        visit_key[visit_fill] = key;
        visit_tbl[visit_fill] = tbl;
        visit_cnt[visit_fill] = 1;
        visit_fill++;
        return 1;
    endfunction

    function automatic hash_result_t make_result(logic [2:0] st, int unsigned slot, bit tbl,
                                                 bit dv, logic [KEY_W-1:0] dk);
        hash_result_t r;
        r.status = st;
        r.slot = slot[9:0];
        r.which_table = tbl;
        r.dropped_valid = dv;
        r.dropped_key = dk;
        return r;
    endfunction

    // Apply one request to the shadow tables and return the expected result beat
    function automatic hash_result_t cuckoo_lookup_update(logic [1:0] act, logic [KEY_W-1:0] key);
        int unsigned n, h, g, idx, cnt;
        bit found, ftbl, tbl, cyc, prev_v;
        int unsigned fslot;
        logic [KEY_W-1:0] carry, prev_k;
        n = modulus_now();
        h = key % n;
        g = (key / n) % n;
        found = 0;
        ftbl = 0;
        fslot = 0;
        if (shadow_valid[0][h] && shadow_key[0][h] == key)
        begin
            found = 1;
            fslot = h;
        end
        else if (shadow_valid[1][g] && shadow_key[1][g] == key)
        begin
            found = 1;
            fslot = g;
            ftbl = 1;
        end
        if (act != ACT_INSERT)
        begin
            if (!found) return make_result(ST_NOTFOUND, 0, 0, 0, '0);
            if (act == ACT_DELETE) shadow_valid[ftbl][fslot] = 0;
            return make_result(ST_DIRECT, fslot, ftbl, 0, '0);
        end
        if (found) return make_result(ST_PRESENT, fslot, ftbl, 0, '0);
        visit_fill = 0;
        if (!shadow_valid[0][h])
        begin
            shadow_valid[0][h] = 1;
            shadow_key[0][h] = key;
            return make_result(ST_DIRECT, h, 0, 0, '0);
        end
        carry = shadow_key[0][h];
        tbl = 1;
        idx = (carry / n) % n;
        cyc = 0;
        shadow_key[0][h] = key;
        void'(log_visit(key, 0));
        // Kick the carried key along until it lands, cycles or runs out of log
        forever
        begin
            cnt = log_visit(carry, tbl);
            if (cnt == 0) return make_result(ST_LOGFULL, h, 0, 1, carry);
            if (cnt >= 3) cyc = 1;
            prev_v = shadow_valid[tbl][idx];
            prev_k = shadow_key[tbl][idx];
            shadow_valid[tbl][idx] = 1;
            shadow_key[tbl][idx] = carry;
            if (!prev_v) return make_result(ST_PLACED, h, 0, 0, '0);
            carry = prev_k;
            if (cyc) return make_result(ST_CYCLE, h, 0, 1, carry);
            if (tbl == 0)
            begin
                tbl = 1;
                idx = (carry / n) % n;
            end
            else
            begin
                tbl = 0;
                idx = carry % n;
            end
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Drive one request beat, wait for it to be taken, then queue its expected result
    task automatic send_request(logic [1:0] act, logic [KEY_W-1:0] key, bit known,
                                hash_result_t want);
        hash_result_t predicted;
        if (tx_idle && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, key, act};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = cuckoo_lookup_update(act, key);
        pending_results.push_back(known ? want : predicted);
        if (act == ACT_INSERT)
        begin
            key_pool.push_back(key);
            if (key_pool.size() > 48) void'(key_pool.pop_front());
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_slots(int unsigned value);
        cfg_wen <= 1'b1;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_wen <= 1'b0;
        slots_reg = value & 11'h7FF;
    endtask

    // Receiver side: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 600;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= rx_idle ? ($urandom_range(99) >= idle_pct) : 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        hash_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[45:0];
            if (pending_results.size() == 0)
            begin
                report_mismatch("result beat with nothing pending", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.slot !== want.slot)
                    report_mismatch("slot", got.slot, want.slot);
                if (got.which_table !== want.which_table)
                    report_mismatch("which_table", got.which_table, want.which_table);
                if (got.dropped_valid !== want.dropped_valid)
                    report_mismatch("dropped_valid", got.dropped_valid, want.dropped_valid);
                if (got.dropped_key !== want.dropped_key)
                    report_mismatch("dropped_key", got.dropped_key, want.dropped_key);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("two_table_cuckoo_hash_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        request_row_t rows[$];
        int unsigned phase_slots[9];
        int unsigned n, r;
        logic [1:0] act;
        logic [KEY_W-1:0] key;
        hash_result_t none;

        phase_slots = '{1, 0, 2, 16, 64, 1024, 2047, 5, 300};
        none = '0;
        slots_reg = CFG_RESET;
        visit_fill = 0;
        foreach (shadow_valid[t, s]) shadow_valid[t][s] = 0;

        // Directed rows at the reset modulus of 1024
        rows.push_back('{ACT_SEARCH, 31'd0, 1, make_result(ST_NOTFOUND, 0, 0, 0, '0)});
        rows.push_back('{ACT_INSERT, 31'd0, 1, make_result(ST_DIRECT, 0, 0, 0, '0)});
        rows.push_back('{ACT_INSERT, 31'd0, 1, make_result(ST_PRESENT, 0, 0, 0, '0)});
        rows.push_back('{ACT_INSERT, 31'h7FFFFFFF, 1, make_result(ST_DIRECT, 1023, 0, 0, '0)});
        rows.push_back('{ACT_SPARE, 31'h7FFFFFFF, 1, make_result(ST_DIRECT, 1023, 0, 0, '0)});
        rows.push_back('{ACT_DELETE, 31'h7FFFFFFF, 1, make_result(ST_DIRECT, 1023, 0, 0, '0)});
        rows.push_back('{ACT_DELETE, 31'h7FFFFFFF, 1, make_result(ST_NOTFOUND, 0, 0, 0, '0)});
        rows.push_back('{ACT_INSERT, 31'd1024, 1, make_result(ST_PLACED, 0, 0, 0, '0)});
        rows.push_back('{ACT_SEARCH, 31'd0, 1, make_result(ST_DIRECT, 0, 1, 0, '0)});
        rows.push_back('{ACT_SPARE, 31'd1024, 1, make_result(ST_DIRECT, 0, 0, 0, '0)});
        rows.push_back('{ACT_INSERT, 31'h55555555, 0, none});
        rows.push_back('{ACT_INSERT, 31'h2AAAAAAA, 0, none});
        rows.push_back('{ACT_INSERT, 31'd2048, 0, none});
        rows.push_back('{ACT_INSERT, 31'd3072, 0, none});
        rows.push_back('{ACT_INSERT, 31'd1048576, 0, none});
        rows.push_back('{ACT_DELETE, 31'd0, 0, none});
        rows.push_back('{ACT_SEARCH, 31'd2048, 0, none});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) send_request(rows[i].act, rows[i].key, rows[i].known, rows[i].res);
        wait_drained();

        // Random phases, one modulus and one idling pattern each
        foreach (phase_slots[p])
        begin
            write_slots(phase_slots[p]);
            tx_idle = (p % 4 == 1) || (p % 4 == 3);
            rx_idle = (p % 4 == 2) || (p % 4 == 3);
            idle_pct = (p % 4 == 3) ? 26 : 77;
            n = modulus_now();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == 30) hold_req = 1'b1;
                if (p == 4 && i == 60) wait_drained();
                r = $urandom_range(99);
                act = (r < 50) ? ACT_INSERT : (r < 75) ? ACT_SEARCH :
                      (r < 95) ? ACT_DELETE : ACT_SPARE;
                r = $urandom_range(99);
                if (r < 45 && key_pool.size() != 0)
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                else if (r < 85)
                    key = KEY_W'($urandom_range(0, n * n * 2));
                else
                    key = KEY_W'($urandom());
                send_request(act, key, 0, none);
            end
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("two_table_cuckoo_hash_top: match");
        else
            $display("two_table_cuckoo_hash_top: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/cth_pkg.sv
src/cth_ram.sv
src/cth_div.sv
src/cth_dp.sv
src/cth_ctrl.sv
src/two_table_cuckoo_hash_top.sv
verif/two_table_cuckoo_hash_top_tb.sv
